### rtl/mss_pkg.sv
// Shared types and constants for the motor safety supervisor.
// Holds the state encoding, status codes, register indexes and beat structs.
// No dependencies.
package mss_pkg;

  typedef enum logic [2:0] {
    FSM_INIT  = 3'd0,
    FSM_OPER  = 3'd1,
    FSM_OFF   = 3'd2,
    FSM_ERROR = 3'd3,
    FSM_SWEM  = 3'd4,
    FSM_HWEM  = 3'd5,
    FSM_LOSS  = 3'd6
  } mss_fsm_t;

  localparam logic [2:0] STS_INIT    = 3'd0;
  localparam logic [2:0] STS_READY   = 3'd1;
  localparam logic [2:0] STS_RUNNING = 3'd2;
  localparam logic [2:0] STS_OFF     = 3'd3;
  localparam logic [2:0] STS_ERROR   = 3'd4;
  localparam logic [2:0] STS_SWEM    = 3'd5;
  localparam logic [2:0] STS_HWEM    = 3'd6;
  localparam logic [2:0] STS_LOSS    = 3'd7;

  localparam logic [1:0] CFG_OVER_TEMP   = 2'd0;
  localparam logic [1:0] CFG_CLEAR_TEMP  = 2'd1;
  localparam logic [1:0] CFG_RECONNECT   = 2'd2;
  localparam logic [1:0] CFG_PING_LIMIT  = 2'd3;

  localparam logic [7:0]  OVER_TEMP_RST  = 8'd70;
  localparam logic [7:0]  CLEAR_TEMP_RST = 8'd60;
  localparam logic [15:0] RECONNECT_RST  = 16'd500;
  localparam logic [3:0]  PING_LIMIT_RST = 4'd3;
  localparam logic [3:0]  PING_CNT_MAX   = 4'd15;

  localparam logic [1:0] PHASE_TEMP = 2'd0;
  localparam logic [1:0] PHASE_IDLE = 2'd1;
  localparam logic [1:0] PHASE_ERR  = 2'd2;

  typedef struct packed {
    logic [7:0]  over_temp_limit;
    logic [7:0]  clear_temp_limit;
    logic [15:0] retry_period_ms;
    logic [3:0]  ping_fail_limit;
  } mss_cfg_t;

  typedef struct packed {
    logic        estop_request;
    logic        master_timeout;
    logic        torque_write;
    logic        torque_value;
    logic        ping_ok;
    logic        moving_flag;
    logic [7:0]  temp_sample;
    logic [7:0]  error_sample;
    logic [31:0] now_ms;
  } mss_item_t;

  typedef struct packed {
    mss_fsm_t    fsm;
    logic [2:0]  status;
    logic        torque_flag;
    logic        post_loss_lock;
    logic [3:0]  ping_fail_count;
    logic [1:0]  read_phase;
    logic [31:0] last_retry_ms;
    logic [7:0]  temp;
    logic [7:0]  error;
  } mss_state_t;

  typedef struct packed {
    logic [2:0] status_code;
    logic       torque_drive;
    logic       reboot_request;
    logic [7:0] latched_temp;
    logic [7:0] latched_error;
  } mss_result_t;

endpackage

### rtl/mss_step.sv
// Next-state and result logic for one supervisor tick.
// Purely combinational; depends on mss_pkg.
module mss_step
  import mss_pkg::*;
(
  input  mss_cfg_t    cfg,
  input  mss_state_t  cur,
  input  mss_item_t   item,
  output mss_state_t  nxt,
  output mss_result_t res
);

  logic        tf;
  logic        reboot;
  logic [3:0]  cnt_inc;
  logic [31:0] elapsed;

  assign tf      = item.torque_write ? item.torque_value : cur.torque_flag;
  assign cnt_inc = (cur.ping_fail_count < PING_CNT_MAX) ?
                   cur.ping_fail_count + 4'd1 : cur.ping_fail_count;
  assign elapsed = item.now_ms - cur.last_retry_ms;

  always_comb begin
    nxt             = cur;
    nxt.torque_flag = tf;
    reboot          = 1'b0;
    unique case (cur.fsm)
      FSM_INIT: begin
        nxt.temp            = 8'd0;
        nxt.ping_fail_count = 4'd0;
        if (!item.ping_ok) begin
          nxt.fsm           = FSM_ERROR;
          nxt.status        = STS_ERROR;
          nxt.last_retry_ms = 32'd0;
        end else begin
          nxt.torque_flag = ~cur.post_loss_lock;
          nxt.fsm         = FSM_OPER;
        end
      end
      FSM_OPER: begin
        if (item.estop_request) begin
          nxt.fsm            = FSM_SWEM;
          nxt.status         = STS_SWEM;
          nxt.torque_flag    = 1'b0;
          nxt.post_loss_lock = 1'b1;
        end else if (item.master_timeout) begin
          nxt.fsm            = FSM_LOSS;
          nxt.status         = STS_LOSS;
          nxt.torque_flag    = 1'b0;
          nxt.post_loss_lock = 1'b1;
        end else if (cur.temp > cfg.over_temp_limit || cur.error != 8'd0) begin
          nxt.fsm         = FSM_HWEM;
          nxt.status      = STS_HWEM;
          nxt.torque_flag = 1'b0;
        end else if (cur.post_loss_lock) begin
          nxt.status = STS_READY;
          if (!tf) begin
            nxt.post_loss_lock = 1'b0;
          end
        end else if (!item.ping_ok) begin
          nxt.ping_fail_count = cnt_inc;
          if (cnt_inc >= cfg.ping_fail_limit) begin
            nxt.ping_fail_count = 4'd0;
            nxt.fsm             = FSM_ERROR;
            nxt.status          = STS_ERROR;
            nxt.temp            = 8'd0;
            nxt.last_retry_ms   = 32'd0;
          end
        end else begin
          nxt.ping_fail_count = 4'd0;
          if (!tf) begin
            nxt.fsm    = FSM_OFF;
            nxt.status = STS_OFF;
          end else begin
            if (cur.read_phase == PHASE_TEMP) begin
              nxt.temp = item.temp_sample;
            end else if (cur.read_phase == PHASE_ERR) begin
              nxt.error = item.error_sample;
            end
            nxt.read_phase = (cur.read_phase == PHASE_IDLE) ? PHASE_ERR :
                             (cur.read_phase == PHASE_ERR)  ? PHASE_TEMP : PHASE_IDLE;
            nxt.status     = item.moving_flag ? STS_RUNNING : STS_READY;
          end
        end
      end
      FSM_OFF: begin
        if (item.estop_request) begin
          nxt.fsm            = FSM_SWEM;
          nxt.status         = STS_SWEM;
          nxt.torque_flag    = 1'b0;
          nxt.post_loss_lock = 1'b1;
        end else if (tf) begin
          nxt.fsm = FSM_OPER;
        end
      end
      FSM_ERROR: begin
        if (elapsed >= {16'd0, cfg.retry_period_ms}) begin
          nxt.last_retry_ms = item.now_ms;
          if (item.ping_ok) begin
            nxt.fsm    = FSM_INIT;
            nxt.status = STS_INIT;
          end
        end
      end
      FSM_SWEM: begin
        if (!item.estop_request) begin
          nxt.fsm = FSM_OPER;
        end
      end
      FSM_HWEM: begin
        nxt.temp  = item.temp_sample;
        nxt.error = item.error_sample;
        if (item.temp_sample < cfg.clear_temp_limit && item.error_sample == 8'd0) begin
          reboot     = 1'b1;
          nxt.fsm    = FSM_INIT;
          nxt.status = STS_INIT;
        end
      end
      FSM_LOSS: begin
        if (!item.master_timeout) begin
          nxt.fsm = FSM_OPER;
        end
      end
      default: begin
        nxt.fsm    = FSM_INIT;
        nxt.status = STS_INIT;
      end
    endcase
  end

  assign res.status_code    = nxt.status;
  assign res.torque_drive   = (nxt.fsm == FSM_OPER) && !nxt.post_loss_lock && nxt.torque_flag;
  assign res.reboot_request = reboot;
  assign res.latched_temp   = nxt.temp;
  assign res.latched_error  = nxt.error;

endmodule

### rtl/motor_safety_supervisor.sv
// Top level of the motor safety supervisor: input register, state, result register.
// Depends on mss_pkg and mss_step.
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid / in_stall | flags, samples, now_ms
//   out_    | output    | out_valid/out_stall | status, torque, reboot, latches
//   cfg_    | input     | cfg_wr_en           | cfg_index, cfg_wdata
//
// One beat per clock without out_stall; a beat goes via input then result register.
// The input register holds one beat while the result register waits on out_stall.
// Reset is synchronous; it clears the state machine, the supervisor state and the
// configuration registers to their defaults. There is no clearing pass.
module motor_safety_supervisor
  import mss_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_estop_request,
  input  logic        in_master_timeout,
  input  logic        in_torque_write,
  input  logic        in_torque_value,
  input  logic        in_ping_ok,
  input  logic        in_moving_flag,
  input  logic [7:0]  in_temp_sample,
  input  logic [7:0]  in_error_sample,
  input  logic [31:0] in_now_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status_code,
  output logic        out_torque_drive,
  output logic        out_reboot_request,
  output logic [7:0]  out_latched_temp,
  output logic [7:0]  out_latched_error,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  mss_cfg_t    cfg_r;
  mss_state_t  state_r;
  mss_state_t  state_nxt;
  mss_item_t   item_r;
  mss_result_t res_nxt;
  mss_result_t res_r;
  logic        item_valid_r;
  logic        out_valid_r;
  logic        advance;

  assign advance  = item_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = item_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.over_temp_limit  <= OVER_TEMP_RST;
      cfg_r.clear_temp_limit <= CLEAR_TEMP_RST;
      cfg_r.retry_period_ms  <= RECONNECT_RST;
      cfg_r.ping_fail_limit  <= PING_LIMIT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_OVER_TEMP:  cfg_r.over_temp_limit  <= cfg_wdata[7:0];
        CFG_CLEAR_TEMP: cfg_r.clear_temp_limit <= cfg_wdata[7:0];
        CFG_RECONNECT:  cfg_r.retry_period_ms  <= cfg_wdata;
        CFG_PING_LIMIT: cfg_r.ping_fail_limit  <= cfg_wdata[3:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      item_valid_r <= 1'b1;
    end else if (advance) begin
      item_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r.estop_request  <= in_estop_request;
      item_r.master_timeout <= in_master_timeout;
      item_r.torque_write   <= in_torque_write;
      item_r.torque_value   <= in_torque_value;
      item_r.ping_ok        <= in_ping_ok;
      item_r.moving_flag    <= in_moving_flag;
      item_r.temp_sample    <= in_temp_sample;
      item_r.error_sample   <= in_error_sample;
      item_r.now_ms         <= in_now_ms;
    end
  end

  mss_step u_step (
    .cfg  (cfg_r),
    .cur  (state_r),
    .item (item_r),
    .nxt  (state_nxt),
    .res  (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.fsm             <= FSM_INIT;
      state_r.status          <= STS_INIT;
      state_r.torque_flag     <= 1'b0;
      state_r.post_loss_lock  <= 1'b0;
      state_r.ping_fail_count <= 4'd0;
      state_r.read_phase      <= PHASE_TEMP;
      state_r.last_retry_ms   <= 32'd0;
      state_r.temp            <= 8'd0;
      state_r.error           <= 8'd0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status_code    = res_r.status_code;
  assign out_torque_drive   = res_r.torque_drive;
  assign out_reboot_request = res_r.reboot_request;
  assign out_latched_temp   = res_r.latched_temp;
  assign out_latched_error  = res_r.latched_error;

endmodule

### rtl/mss_checker.sv
// Port-level checks for the motor safety supervisor and the bind that attaches them.
// Depends on mss_pkg and the motor_safety_supervisor ports.
module mss_port_checker
  import mss_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_status_code,
  input logic        out_torque_drive,
  input logic        out_reboot_request,
  input logic [7:0]  out_latched_temp,
  input logic [7:0]  out_latched_error
);

  // A reboot is only requested when a hardware emergency clears into init.
  a_reboot_init: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_reboot_request |->
      out_status_code == STS_INIT && out_latched_error == 8'd0 && !out_torque_drive)
    else $error("reboot request without a clean return to init");

  // Torque is never driven while an error or emergency status is reported.
  a_torque_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_torque_drive |->
      out_status_code != STS_ERROR && out_status_code != STS_SWEM &&
      out_status_code != STS_HWEM && out_status_code != STS_LOSS)
    else $error("torque driven during a fault status");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status_code) &&
      $stable(out_torque_drive) && $stable(out_reboot_request) &&
      $stable(out_latched_temp) && $stable(out_latched_error))
    else $error("stalled result beat changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat present right after reset");

endmodule

bind motor_safety_supervisor mss_port_checker u_mss_checker (.*);

### test/mss_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the motor safety supervisor: watches the input, result and register ports,
// predicts each result beat from its own copy of the supervisor state and compares.
// Depends on mss_pkg for the state encoding, status codes and register indexes.
module mss_checker
  import mss_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_estop_request,
  input  logic        in_master_timeout,
  input  logic        in_torque_write,
  input  logic        in_torque_value,
  input  logic        in_ping_ok,
  input  logic        in_moving_flag,
  input  logic [7:0]  in_temp_sample,
  input  logic [7:0]  in_error_sample,
  input  logic [31:0] in_now_ms,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  out_status_code,
  input  logic        out_torque_drive,
  input  logic        out_reboot_request,
  input  logic [7:0]  out_latched_temp,
  input  logic [7:0]  out_latched_error,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  output int unsigned outstanding,
  output int unsigned failures,
  output int unsigned checked
);

  mss_state_t  sup;
  mss_cfg_t    lim;
  mss_item_t   tick_beat;
  mss_result_t status_beat;
  mss_result_t wanted;
  mss_result_t predicted_status_q[$];
  int unsigned mismatch_count = 0;
  int unsigned compared_count = 0;

  assign tick_beat = {in_estop_request, in_master_timeout, in_torque_write, in_torque_value,
                      in_ping_ok, in_moving_flag, in_temp_sample, in_error_sample, in_now_ms};
  assign status_beat = {out_status_code, out_torque_drive, out_reboot_request,
                        out_latched_temp, out_latched_error};
  assign failures = mismatch_count;
  assign checked = compared_count;

  function automatic void go_error();
    sup.fsm = FSM_ERROR;
    sup.status = STS_ERROR;
    sup.temp = '0;
    sup.last_retry_ms = '0;
  endfunction

  function automatic void go_sw_emergency();
    sup.fsm = FSM_SWEM;
    sup.status = STS_SWEM;
    sup.torque_flag = 1'b0;
    sup.post_loss_lock = 1'b1;
  endfunction

  function automatic void go_init();
    sup.fsm = FSM_INIT;
    sup.status = STS_INIT;
  endfunction

  function automatic mss_result_t supervise(input mss_item_t t);
    mss_result_t r;
    logic        reboot;
    logic [31:0] elapsed;
    logic [2:0]  next_phase;
    reboot = 1'b0;
    if (t.torque_write) sup.torque_flag = t.torque_value;
    case (sup.fsm)
      FSM_INIT: begin
        sup.temp = '0;
        sup.ping_fail_count = '0;
        if (!t.ping_ok) begin
          go_error();
        end else begin
          sup.torque_flag = !sup.post_loss_lock;
          sup.fsm = FSM_OPER;
        end
      end
      FSM_OPER: begin
        if (t.estop_request) begin
          go_sw_emergency();
        end else if (t.master_timeout) begin
          sup.fsm = FSM_LOSS;
          sup.status = STS_LOSS;
          sup.torque_flag = 1'b0;
          sup.post_loss_lock = 1'b1;
        end else if (sup.temp > lim.over_temp_limit || sup.error != 8'd0) begin
          sup.fsm = FSM_HWEM;
          sup.status = STS_HWEM;
          sup.torque_flag = 1'b0;
        end else if (sup.post_loss_lock) begin
          sup.status = STS_READY;
          if (!sup.torque_flag) sup.post_loss_lock = 1'b0;
        end else if (!t.ping_ok) begin
          if (sup.ping_fail_count < PING_CNT_MAX) sup.ping_fail_count++;
          if (sup.ping_fail_count >= lim.ping_fail_limit) begin
            sup.ping_fail_count = '0;
            go_error();
          end
        end else begin
          sup.ping_fail_count = '0;
          if (!sup.torque_flag) begin
            sup.fsm = FSM_OFF;
            sup.status = STS_OFF;
          end else begin
            if (sup.read_phase == PHASE_TEMP) sup.temp = t.temp_sample;
            else if (sup.read_phase == PHASE_ERR) sup.error = t.error_sample;
            next_phase = ({1'b0, sup.read_phase} + 3'd1) % 3'd3;
            sup.read_phase = next_phase[1:0];
            sup.status = t.moving_flag ? STS_RUNNING : STS_READY;
          end
        end
      end
      FSM_OFF: begin
        if (t.estop_request) go_sw_emergency();
        else if (sup.torque_flag) sup.fsm = FSM_OPER;
      end
      FSM_ERROR: begin
        elapsed = t.now_ms - sup.last_retry_ms;
        if (elapsed >= {16'd0, lim.retry_period_ms}) begin
          sup.last_retry_ms = t.now_ms;
          if (t.ping_ok) go_init();
        end
      end
      FSM_SWEM: begin
        if (!t.estop_request) sup.fsm = FSM_OPER;
      end
      FSM_HWEM: begin
        sup.temp = t.temp_sample;
        sup.error = t.error_sample;
        if (sup.temp < lim.clear_temp_limit && sup.error == 8'd0) begin
          reboot = 1'b1;
          go_init();
        end
      end
      FSM_LOSS: begin
        if (!t.master_timeout) sup.fsm = FSM_OPER;
      end
      default: go_init();
    endcase
    r.status_code = sup.status;
    r.torque_drive = (sup.fsm == FSM_OPER) && !sup.post_loss_lock && sup.torque_flag;
    r.reboot_request = reboot;
    r.latched_temp = sup.temp;
    r.latched_error = sup.error;
    return r;
  endfunction

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      sup = '0;
      sup.fsm = FSM_INIT;
      lim.over_temp_limit = OVER_TEMP_RST;
      lim.clear_temp_limit = CLEAR_TEMP_RST;
      lim.retry_period_ms = RECONNECT_RST;
      lim.ping_fail_limit = PING_LIMIT_RST;
      predicted_status_q.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_OVER_TEMP:  lim.over_temp_limit = cfg_wdata[7:0];
          CFG_CLEAR_TEMP: lim.clear_temp_limit = cfg_wdata[7:0];
          CFG_RECONNECT:  lim.retry_period_ms = cfg_wdata;
          CFG_PING_LIMIT: lim.ping_fail_limit = cfg_wdata[3:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predicted_status_q.push_back(supervise(tick_beat));
      if (out_valid && !out_stall) begin
        if (predicted_status_q.size() == 0) begin
          $display("%0t: result beat expected none, got status %0d", $time,
                   out_status_code);
          mismatch_count++;
        end else begin
          wanted = predicted_status_q.pop_front();
          compare_field("status_code", wanted.status_code, status_beat.status_code);
          compare_field("torque_drive", wanted.torque_drive, status_beat.torque_drive);
          compare_field("reboot_request", wanted.reboot_request, status_beat.reboot_request);
          compare_field("latched_temp", wanted.latched_temp, status_beat.latched_temp);
          compare_field("latched_error", wanted.latched_error, status_beat.latched_error);
          compared_count++;
        end
      end
    end
    outstanding <= predicted_status_q.size();
  end

endmodule

### test/tb_motor_safety_supervisor.sv
`timescale 1ns / 1ps
// Testbench top for the motor safety supervisor: clock, reset, tick stimulus, output
// stalls and limit register writes. Depends on mss_pkg, the block and mss_checker.
module tb_motor_safety_supervisor;
  import mss_pkg::*;

  localparam int PHASES = 6;
  localparam int HOLD_CYCLES = 80;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_estop_request = 1'b0;
  logic        in_master_timeout = 1'b0;
  logic        in_torque_write = 1'b0;
  logic        in_torque_value = 1'b0;
  logic        in_ping_ok = 1'b0;
  logic        in_moving_flag = 1'b0;
  logic [7:0]  in_temp_sample = '0;
  logic [7:0]  in_error_sample = '0;
  logic [31:0] in_now_ms = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status_code;
  logic        out_torque_drive;
  logic        out_reboot_request;
  logic [7:0]  out_latched_temp;
  logic [7:0]  out_latched_error;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  int unsigned outstanding;
  int unsigned failures;
  int unsigned checked;

  logic        stalls_on = 1'b1;
  logic        want_hold = 1'b0;
  logic        hold_done = 1'b0;
  bit          gaps_on = 1'b1;
  int unsigned ticks_sent = 0;
  int unsigned estop_left = 0;
  int unsigned timeout_left = 0;
  logic [31:0] clock_ms = '0;

  int unsigned phase_ticks [PHASES] = '{300, 200, 100, 250, 250, 250};
  logic [15:0] over_set    [PHASES] = '{70, 0, 255, 255, 100, 0};
  logic [15:0] clear_set   [PHASES] = '{60, 255, 0, 128, 90, 0};
  logic [15:0] period_set  [PHASES] = '{500, 0, 65535, 1, 1000, 0};
  logic [15:0] limit_set   [PHASES] = '{3, 0, 15, 1, 7, 0};

  motor_safety_supervisor i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_estop_request   (in_estop_request),
    .in_master_timeout  (in_master_timeout),
    .in_torque_write    (in_torque_write),
    .in_torque_value    (in_torque_value),
    .in_ping_ok         (in_ping_ok),
    .in_moving_flag     (in_moving_flag),
    .in_temp_sample     (in_temp_sample),
    .in_error_sample    (in_error_sample),
    .in_now_ms          (in_now_ms),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status_code    (out_status_code),
    .out_torque_drive   (out_torque_drive),
    .out_reboot_request (out_reboot_request),
    .out_latched_temp   (out_latched_temp),
    .out_latched_error  (out_latched_error),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  mss_checker i_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_estop_request   (in_estop_request),
    .in_master_timeout  (in_master_timeout),
    .in_torque_write    (in_torque_write),
    .in_torque_value    (in_torque_value),
    .in_ping_ok         (in_ping_ok),
    .in_moving_flag     (in_moving_flag),
    .in_temp_sample     (in_temp_sample),
    .in_error_sample    (in_error_sample),
    .in_now_ms          (in_now_ms),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status_code    (out_status_code),
    .out_torque_drive   (out_torque_drive),
    .out_reboot_request (out_reboot_request),
    .out_latched_temp   (out_latched_temp),
    .out_latched_error  (out_latched_error),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .outstanding        (outstanding),
    .failures           (failures),
    .checked            (checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic mss_item_t make_tick(input bit estop, input bit timeout, input bit twr,
                                          input bit tval, input bit ping, input bit moving,
                                          input logic [7:0] temp, input logic [7:0] err,
                                          input logic [31:0] ms);
    mss_item_t t;
    t = {estop, timeout, twr, tval, ping, moving, temp, err, ms};
    return t;
  endfunction

  // Mostly healthy ticks with held stop and timeout requests, rare faults and
  // a small share of fully random beats.
  function automatic mss_item_t random_tick();
    mss_item_t   t;
    int unsigned pick;
    logic [63:0] raw;
    pick = $urandom_range(99);
    if (pick < 5) begin
      raw = {$urandom, $urandom};
      t = raw[$bits(mss_item_t)-1:0];
      return t;
    end
    if (estop_left == 0 && pick < 8) estop_left = $urandom_range(1, 6);
    else if (timeout_left == 0 && pick >= 8 && pick < 11) timeout_left = $urandom_range(1, 6);
    t.estop_request = (estop_left != 0);
    t.master_timeout = (timeout_left != 0);
    if (estop_left != 0) estop_left--;
    if (timeout_left != 0) timeout_left--;
    t.torque_write = ($urandom_range(99) < 8);
    t.torque_value = ($urandom_range(99) < 85);
    t.ping_ok = ($urandom_range(99) < 92);
    t.moving_flag = 1'($urandom_range(1));
    pick = $urandom_range(99);
    if (pick < 85) t.temp_sample = 8'($urandom_range(20, 65));
    else if (pick < 95) t.temp_sample = 8'($urandom_range(60, 90));
    else t.temp_sample = 8'($urandom_range(255));
    t.error_sample = ($urandom_range(99) < 4) ? 8'($urandom_range(1, 255)) : 8'd0;
    if ($urandom_range(99) < 3) clock_ms = $urandom;
    else clock_ms = clock_ms + $urandom_range(0, 400);
    t.now_ms = clock_ms;
    return t;
  endfunction

  task automatic send_tick(input mss_item_t t);
    if (gaps_on && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_estop_request <= t.estop_request;
    in_master_timeout <= t.master_timeout;
    in_torque_write <= t.torque_write;
    in_torque_value <= t.torque_value;
    in_ping_ok <= t.ping_ok;
    in_moving_flag <= t.moving_flag;
    in_temp_sample <= t.temp_sample;
    in_error_sample <= t.error_sample;
    in_now_ms <= t.now_ms;
    do @(posedge clk); while (in_stall);
    ticks_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_limits(input logic [15:0] over, input logic [15:0] clear,
                             input logic [15:0] period, input logic [15:0] limit);
    logic [15:0] vals [4];
    logic [1:0]  idx [4];
    vals = '{over, clear, period, limit};
    idx = '{CFG_OVER_TEMP, CFG_CLEAR_TEMP, CFG_RECONNECT, CFG_PING_LIMIT};
    for (int k = 0; k < 4; k++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= idx[k];
      cfg_wdata <= vals[k];
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (want_hold && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!stalls_on) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(2) == 0);
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the main transitions under the reset limits, then the 32-bit timestamp wrap.
    send_tick(make_tick(0, 0, 0, 0, 0, 0, 8'd0,   8'd0,   32'd0));
    send_tick(make_tick(0, 0, 0, 0, 1, 0, 8'd0,   8'd0,   32'd100));
    send_tick(make_tick(0, 0, 0, 0, 1, 0, 8'd0,   8'd0,   32'd600));
    send_tick(make_tick(0, 0, 0, 0, 1, 0, 8'd0,   8'd0,   32'd601));
    send_tick(make_tick(0, 0, 0, 0, 1, 1, 8'hFF,  8'd0,   32'd602));
    send_tick(make_tick(0, 0, 0, 0, 1, 0, 8'hFF,  8'hFF,  32'd603));
    send_tick(make_tick(0, 0, 0, 0, 1, 0, 8'd59,  8'd0,   32'd604));
    send_tick(make_tick(0, 0, 0, 0, 1, 0, 8'd30,  8'd0,   32'd605));
    send_tick(make_tick(1, 0, 0, 0, 1, 0, 8'd30,  8'd0,   32'd606));
    send_tick(make_tick(1, 0, 0, 0, 1, 0, 8'd30,  8'd0,   32'd607));
    send_tick(make_tick(0, 0, 0, 0, 1, 0, 8'd30,  8'd0,   32'd608));
    send_tick(make_tick(0, 0, 0, 0, 1, 0, 8'd30,  8'd0,   32'd609));
    send_tick(make_tick(0, 0, 0, 0, 1, 0, 8'd30,  8'd0,   32'd610));
    send_tick(make_tick(0, 0, 1, 1, 1, 1, 8'd30,  8'd0,   32'd611));
    send_tick(make_tick(0, 1, 0, 0, 1, 1, 8'd30,  8'd0,   32'd612));
    send_tick(make_tick(0, 1, 0, 0, 1, 1, 8'd30,  8'd0,   32'd613));
    send_tick(make_tick(0, 0, 1, 1, 1, 1, 8'd30,  8'd0,   32'd614));
    send_tick(make_tick(0, 0, 1, 0, 1, 1, 8'd30,  8'd0,   32'd615));
    send_tick(make_tick(0, 0, 1, 1, 1, 0, 8'd30,  8'd0,   32'd616));
    send_tick(make_tick(0, 0, 0, 0, 0, 0, 8'd30,  8'd0,   32'd617));
    send_tick(make_tick(0, 0, 0, 0, 0, 0, 8'd30,  8'd0,   32'd618));
    send_tick(make_tick(0, 0, 0, 0, 0, 0, 8'd30,  8'd0,   32'd619));
    send_tick(make_tick(0, 0, 0, 0, 0, 0, 8'd0,   8'd0,   32'hFFFF_FF00));
    send_tick(make_tick(0, 0, 0, 0, 1, 0, 8'd0,   8'd0,   32'h0000_0100));
    send_tick(make_tick(0, 0, 0, 0, 1, 1, 8'd0,   8'hFF,  32'h0000_0101));
    clock_ms = 32'h0000_0200;

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        wait_drained();
        if (p == PHASES - 1) begin
          load_limits(16'($urandom_range(40, 120)), 16'($urandom_range(20, 100)),
                      16'($urandom_range(1, 2000)), 16'($urandom_range(1, 15)));
          gaps_on = 1'b0;
          stalls_on <= 1'b0;
        end else begin
          load_limits(over_set[p], clear_set[p], period_set[p], limit_set[p]);
        end
        if (p == 1) want_hold <= 1'b1;
      end
      for (int n = 0; n < phase_ticks[p]; n++) send_tick(random_tick());
    end

    wait_drained();
    $display("Ran %0d supervisor ticks through %0d limit settings with random gaps,", ticks_sent,
             PHASES);
    $display("output stalls and one long output hold; %0d result beats compared.", checked);
    if (failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
